### hdl/clock_pram_xpram_access_core_macros.svh
// assertion helpers used by the core's controller
`ifndef CLOCK_PRAM_XPRAM_ACCESS_CORE_MACROS_SVH
`define CLOCK_PRAM_XPRAM_ACCESS_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CPX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CPX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cpx_pkg.sv
package cpx_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CW_W      = 16;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned RAM_DEPTH = 256;
  localparam int unsigned KIND_W    = 2;

  // access kinds reported with each result
  localparam logic [KIND_W-1:0] KIND_EXT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLASSIC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOCK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic CFG_IDX_ROM32 = 1'b0;
  localparam logic CFG_IDX_A24   = 1'b1;

  // special addresses of the parameter ram
  localparam logic [ADDR_W-1:0] ADDR_ROM_MODE = 8'h08;
  localparam logic [ADDR_W-1:0] ADDR_MODE     = 8'h8a;
  localparam logic [ADDR_W-1:0] ADDR_NET0     = 8'he0;
  localparam logic [ADDR_W-1:0] ADDR_NET1     = 8'he1;
  localparam logic [ADDR_W-1:0] ADDR_NET2     = 8'he2;
  localparam logic [ADDR_W-1:0] ADDR_NET3     = 8'he3;

  // override values
  localparam logic [7:0] ROM_MODE_MASK = 8'hf8;
  localparam logic [7:0] MODE_FORCE    = 8'h05;
  localparam logic [7:0] NET0_OFF      = 8'h00;
  localparam logic [7:0] NET1_OFF      = 8'hf1;
  localparam logic [7:0] NET2_OFF      = 8'h00;
  localparam logic [7:0] NET3_OFF      = 8'h0a;

  // command field: bits 6..3 equal to this select extended ram
  localparam logic [3:0] EXT_SELECT = 4'b0111;

  typedef struct packed {
    logic load;    // latch the accepted item
    logic mem_rd;  // read the ram at the decoded address
    logic exec;    // build the result and write back
  } cpx_cmd_t;

endpackage

### hdl/cpx_ctrl.sv
`include "clock_pram_xpram_access_core_macros.svh"

module cpx_ctrl
  import cpx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cpx_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q    <= ST_READ;
            in_stall_q <= 1'b1;
          end
        end
        ST_READ: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q     <= ST_OUT;
          out_valid_q <= 1'b1;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_stall_q  <= 1'b0;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o   = in_stall_q;
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = in_valid_i && !in_stall_q;
  assign cmd_o.mem_rd = (state_q == ST_READ);
  assign cmd_o.exec   = (state_q == ST_EXEC);

  `CPX_ASSERT_IMP(a_out_blocks_in, out_valid_o, in_stall_o, "input open while result pending")
  `CPX_ASSERT_NXT(a_accept_reads, cmd_o.load, cmd_o.mem_rd, "accepted item not read next")
  `CPX_ASSERT_NXT(a_exec_shows, cmd_o.exec, out_valid_o, "result not shown after execute")
  `CPX_ASSERT_IMP(a_idle_ready, (state_q == ST_IDLE), !in_stall_o, "idle controller stalls")

endmodule

### hdl/cpx_dp.sv
module cpx_dp
  import cpx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpx_cmd_t          cmd_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic              cfg_data_i,
  input  logic              req_type_i,
  input  logic [CW_W-1:0]   command_word_i,
  input  logic [DATA_W-1:0] data_in_i,
  input  logic [DATA_W-1:0] time_now_i,
  output logic [DATA_W-1:0] data_out_o,
  output logic [KIND_W-1:0] access_kind_o
);

  // configuration
  logic rom32_q;
  logic a24_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom32_q <= 1'b1;
      a24_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_ROM32: rom32_q <= cfg_data_i;
        CFG_IDX_A24:   a24_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  logic              req_q;
  logic [CW_W-1:0]   cw_q;
  logic [DATA_W-1:0] din_q;
  logic [DATA_W-1:0] tnow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      cw_q   <= command_word_i;
      din_q  <= data_in_i;
      tnow_q <= time_now_i;
    end
  end

  // decode
  logic              rd;
  logic              ext;
  logic              classic;
  logic              clk_rd;
  logic [4:0]        reg_sel;
  logic [ADDR_W-1:0] ext_addr;
  logic [ADDR_W-1:0] addr;

  assign rd       = cw_q[7];
  assign ext      = (cw_q[6:3] == EXT_SELECT);
  assign reg_sel  = cw_q[6:2];
  assign ext_addr = {cw_q[2:0], cw_q[14:10]};
  assign classic  = reg_sel[4] | (reg_sel[3] & ~reg_sel[2]);
  assign clk_rd   = ~reg_sel[4] & ~reg_sel[3] & rd;

  always_comb begin
    if (req_q) begin
      addr = cw_q[ADDR_W-1:0];
    end else if (ext) begin
      addr = ext_addr;
    end else begin
      addr = {3'b000, reg_sel};
    end
  end

  // parameter ram with per-entry written flags; unwritten entries read zero
  logic [7:0]           ram_q [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] vld_q;
  logic [7:0]           rdata_q;
  logic                 hit_q;
  logic [7:0]           net0_q;
  logic [7:0]           net1_q;
  logic                 we;
  logic [7:0]           wbyte;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rdata_q <= ram_q[addr];
    end
    if (we) begin
      ram_q[addr] <= wbyte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      hit_q  <= 1'b0;
      net0_q <= 8'h00;
      net1_q <= 8'h00;
    end else begin
      if (cmd_i.mem_rd) begin
        hit_q <= vld_q[addr];
      end
      if (we) begin
        vld_q[addr] <= 1'b1;
        if (addr == ADDR_NET0) begin
          net0_q <= wbyte;
        end
        if (addr == ADDR_NET1) begin
          net1_q <= wbyte;
        end
      end
    end
  end

  // result
  logic [7:0]        rbyte;
  logic [7:0]        xbyte;
  logic              lt_off;
  logic [7:0]        tbyte;
  logic [DATA_W-1:0] dout_d;
  logic [KIND_W-1:0] kind_d;
  logic [DATA_W-1:0] dout_q;
  logic [KIND_W-1:0] kind_q;

  assign rbyte  = hit_q ? rdata_q : 8'h00;
  assign lt_off = (net0_q == 8'h00) && (net1_q == 8'h00);
  assign tbyte  = tnow_q[{reg_sel[1:0], 3'b000} +: 8];

  // fixed overrides on extended reads
  always_comb begin
    xbyte = rbyte;
    case (addr)
      ADDR_ROM_MODE: if (!rom32_q) xbyte = rbyte & ROM_MODE_MASK;
      ADDR_MODE:     xbyte = rbyte | MODE_FORCE;
      ADDR_NET0:     if (lt_off) xbyte = NET0_OFF;
      ADDR_NET1:     if (lt_off) xbyte = NET1_OFF;
      ADDR_NET2:     if (lt_off) xbyte = NET2_OFF;
      ADDR_NET3:     if (lt_off) xbyte = NET3_OFF;
      default: ;
    endcase
  end

  always_comb begin
    dout_d = din_q;
    kind_d = KIND_IGNORED;
    if (req_q) begin
      dout_d = {{(DATA_W-8){1'b0}}, rbyte};
      kind_d = KIND_EXT;
    end else if (ext) begin
      kind_d = KIND_EXT;
      if (rd) begin
        dout_d = {{(DATA_W-8){1'b0}}, xbyte};
      end else if ((addr == ADDR_MODE) && !a24_q) begin
        dout_d = din_q | {{(DATA_W-8){1'b0}}, MODE_FORCE};
      end
    end else if (classic) begin
      kind_d = KIND_CLASSIC;
      if (rd) begin
        dout_d = {{(DATA_W-8){1'b0}}, rbyte};
      end
    end else if (clk_rd) begin
      kind_d = KIND_CLOCK;
      dout_d = {{(DATA_W-8){1'b0}}, tbyte};
    end
  end

  assign we    = cmd_i.exec && !req_q && !rd && (ext || classic);
  assign wbyte = dout_d[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      dout_q <= dout_d;
      kind_q <= kind_d;
    end
  end

  assign data_out_o    = dout_q;
  assign access_kind_o = kind_q;

endmodule

### hdl/clock_pram_xpram_access_core.sv
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_stall_o   req_type_i, command_word_i, data_in_i, time_now_i
// out       out  out_valid_o / out_stall_i data_out_o, access_kind_o
// cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// result valid after the read state and the execute state: ram read, then modify, write back
// and output register, done as a single-port ram read/modify/write
// one item in flight at a time: a new item is not taken until the result has left the output
// reset marks every ram byte unwritten through per-entry flags; no clearing pass
// input stays stalled from the transfer until the result has been taken
module clock_pram_xpram_access_core
  import cpx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic              cfg_data_i,
  // command channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [CW_W-1:0]   command_word_i,
  input  logic [DATA_W-1:0] data_in_i,
  input  logic [DATA_W-1:0] time_now_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] data_out_o,
  output logic [KIND_W-1:0] access_kind_o
);

  // sequencing commands from the controller to the datapath
  cpx_cmd_t cmd;

  // controller: walks each transfer through read, execute and result hold
  cpx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath: command decode, parameter ram, read overrides, write forcing
  cpx_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .command_word_i (command_word_i),
    .data_in_i      (data_in_i),
    .time_now_i     (time_now_i),
    .data_out_o     (data_out_o),
    .access_kind_o  (access_kind_o)
  );

endmodule
